/* hdl/lfpc_pkg.sv */
// Shared types, register map and reset values for the line follower PWM controller.
`default_nettype none

package lfpc_pkg;

    localparam int LINE_W    = 5;
    localparam int SPEED_W   = 6;
    localparam int UNITS_W   = 8;
    localparam int TICKS_W   = 16;
    localparam int HOLD_W    = 24;
    localparam int COUNT_W   = 8;
    localparam int S_DATA_W  = 8;
    localparam int M_DATA_W  = 16;
    localparam int CFG_AW    = 5;
    localparam int CFG_DW    = 32;
    localparam int CENTRE_BIT = 2;

    localparam logic [SPEED_W-1:0] RST_PWM_PERIOD      = 6'd20;
    localparam logic [SPEED_W-1:0] RST_FULL_SPEED      = 6'd20;
    localparam logic [SPEED_W-1:0] RST_TRIM_SPEED      = 6'd15;
    localparam logic [UNITS_W-1:0] RST_NORMAL_HOLD     = 8'd10;
    localparam logic [UNITS_W-1:0] RST_LONG_HOLD       = 8'd90;
    localparam logic [COUNT_W-1:0] RST_CROSSING_TARGET = 8'd3;
    localparam logic [TICKS_W-1:0] RST_TICKS_PER_UNIT  = 16'd1000;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;

    typedef enum logic [2:0] {
        REG_PWM_PERIOD      = 3'd0,
        REG_FULL_SPEED      = 3'd1,
        REG_TRIM_SPEED      = 3'd2,
        REG_NORMAL_HOLD     = 3'd3,
        REG_LONG_HOLD       = 3'd4,
        REG_CROSSING_TARGET = 3'd5,
        REG_TICKS_PER_UNIT  = 3'd6
    } reg_index_t;

    typedef struct packed {
        logic [SPEED_W-1:0] pwm_period;
        logic [SPEED_W-1:0] full_speed;
        logic [SPEED_W-1:0] trim_speed;
        logic [UNITS_W-1:0] normal_hold;
        logic [UNITS_W-1:0] long_hold;
        logic [COUNT_W-1:0] crossing_target;
        logic [TICKS_W-1:0] ticks_per_unit;
    } cfg_t;

    typedef struct packed {
        logic [SPEED_W-1:0] pwm_phase;
        logic [HOLD_W-1:0]  hold_left;
        logic [SPEED_W-1:0] speed_a;
        logic [SPEED_W-1:0] speed_b;
        logic               centre_prev_white;
        logic [COUNT_W-1:0] crossing_count;
    } drive_state_t;

    typedef struct packed {
        logic [COUNT_W-1:0] crossings;
        logic               busy_res;
        logic               forward_b;
        logic               enable_b;
        logic               forward_a;
        logic               enable_a;
    } result_t;

endpackage

`default_nettype wire

/* hdl/lfpc_step.sv */
// One PWM tick: crossing count, pattern table, command load and drive compare.
`default_nettype none

module lfpc_step
    import lfpc_pkg::*;
(
    input  wire cfg_t               cfg,
    input  wire drive_state_t       state,
    input  wire [LINE_W-1:0]        line_bits,
    output drive_state_t            state_next,
    output result_t                 result
);

    logic                 idle;
    logic                 centre;
    logic [COUNT_W-1:0]   count_new;
    logic                 s0, s1, s2, s3, s4;
    logic [3:0]           pat;
    logic                 match;
    logic                 use_long;
    logic [SPEED_W-1:0]   pick_a;
    logic [SPEED_W-1:0]   pick_b;
    logic [UNITS_W-1:0]   units;
    logic [HOLD_W-1:0]    hold_loaded;
    logic [SPEED_W-1:0]   speed_a_loaded;
    logic [SPEED_W-1:0]   speed_b_loaded;
    logic                 drive;
    logic                 ena;
    logic                 enb;
    logic [SPEED_W:0]     phase_inc;

    always_comb begin
        idle   = (state.hold_left == '0);
        centre = line_bits[CENTRE_BIT];
        s0 = line_bits[0];
        s1 = line_bits[1];
        s2 = line_bits[2];
        s3 = line_bits[3];
        s4 = line_bits[4];
        pat = {s4, s3, s1, s0};

        count_new = state.crossing_count;
        if (idle && state.centre_prev_white && !centre && state.crossing_count != COUNT_MAX) begin
            count_new = state.crossing_count + 1'b1;
        end

        match    = 1'b1;
        use_long = 1'b0;
        pick_a   = '0;
        pick_b   = '0;
        if (s4 && !s1 && !s0 && !s2 && count_new == cfg.crossing_target) begin
            pick_b   = cfg.full_speed;
            use_long = 1'b1;
        end else if (pat == 4'd15 || pat == 4'd0) begin
            pick_a = cfg.full_speed;
            pick_b = cfg.full_speed;
        end else if (pat == 4'd11) begin
            pick_a = cfg.full_speed;
            pick_b = cfg.trim_speed;
        end else if (pat == 4'd13) begin
            pick_a = cfg.trim_speed;
            pick_b = cfg.full_speed;
        end else if (pat == 4'd14 || (pat == 4'd8 && s2) || (pat == 4'd12 && s2)) begin
            pick_b = cfg.full_speed;
        end else if (pat == 4'd7 || pat == 4'd1 || pat == 4'd3) begin
            pick_a = cfg.full_speed;
        end else begin
            match = 1'b0;
        end

        units = use_long ? cfg.long_hold : cfg.normal_hold;

        hold_loaded    = state.hold_left;
        speed_a_loaded = state.speed_a;
        speed_b_loaded = state.speed_b;
        if (idle && match) begin
            hold_loaded    = HOLD_W'(units * cfg.ticks_per_unit);
            speed_a_loaded = pick_a;
            speed_b_loaded = pick_b;
        end

        drive = (hold_loaded != '0);
        ena   = drive && (state.pwm_phase < speed_a_loaded);
        enb   = drive && (state.pwm_phase < speed_b_loaded);
        phase_inc = {1'b0, state.pwm_phase} + 1'b1;

        state_next.speed_a           = speed_a_loaded;
        state_next.speed_b           = speed_b_loaded;
        state_next.crossing_count    = count_new;
        state_next.centre_prev_white = idle ? centre : state.centre_prev_white;
        state_next.hold_left         = drive ? hold_loaded - 1'b1 : hold_loaded;
        state_next.pwm_phase         = state.pwm_phase;
        if (drive) begin
            state_next.pwm_phase = (phase_inc >= {1'b0, cfg.pwm_period}) ? '0
                                                                         : phase_inc[SPEED_W-1:0];
        end

        result.enable_a  = ena;
        result.forward_a = ena;
        result.enable_b  = enb;
        result.forward_b = enb;
        result.busy_res  = drive;
        result.crossings = count_new;
    end

endmodule

`default_nettype wire

/* hdl/line_follower_pwm_controller.sv */
// Top level of the line follower PWM controller: stream ports, register file and state.
//
//  channel | direction | word                      | bits
//  s_      | in        | line_bits                 | tdata[4:0]
//  m_      | out       | enable/forward a/b, busy, | tdata[12:0]
//          |           | crossings                 |
//  apb     | in/out    | seven config registers    | paddr 4*i, 32-bit data
//
// One word per cycle sustained while the output is not stalled; each word is held in
// the input register and is evaluated on its way into the output register.
// The step logic holds one 8x16 multiply and the drive compare.
// Reset returns config registers to defaults and clears the drive state, but sets centre_prev_white.
// A stalled output holds its word; one more input word is held behind it.
`default_nettype none

module line_follower_pwm_controller
    import lfpc_pkg::*;
(
    input  wire                  aclk,
    input  wire                  aresetn,

    input  wire                  s_tvalid,
    output logic                 s_tready,
    input  wire [S_DATA_W-1:0]   s_tdata,   // [4:0] line_bits

    output logic                 m_tvalid,
    input  wire                  m_tready,
    output logic [M_DATA_W-1:0]  m_tdata,   // [0] enable_a, [1] forward_a, [2] enable_b,
                                            // [3] forward_b, [4] busy_res, [12:5] crossings

    input  wire                  psel,
    input  wire                  penable,
    input  wire                  pwrite,
    input  wire [CFG_AW-1:0]     paddr,
    input  wire [CFG_DW-1:0]     pwdata,
    output logic [CFG_DW-1:0]    prdata,
    output logic                 pready
);

    cfg_t                cfg_reg;
    cfg_t                cfg_next;
    drive_state_t        state_reg;
    drive_state_t        state_next;
    drive_state_t        state_step;
    result_t             result;
    logic                in_valid_reg;
    logic                in_valid_next;
    logic [LINE_W-1:0]   in_bits_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    result_t             out_data_reg;
    logic                advance;
    logic                cfg_write;
    reg_index_t          cfg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = reg_index_t'(paddr[4:2]);

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_write) begin
            case (cfg_index)
                REG_PWM_PERIOD:      cfg_next.pwm_period      = pwdata[SPEED_W-1:0];
                REG_FULL_SPEED:      cfg_next.full_speed      = pwdata[SPEED_W-1:0];
                REG_TRIM_SPEED:      cfg_next.trim_speed      = pwdata[SPEED_W-1:0];
                REG_NORMAL_HOLD:     cfg_next.normal_hold     = pwdata[UNITS_W-1:0];
                REG_LONG_HOLD:       cfg_next.long_hold       = pwdata[UNITS_W-1:0];
                REG_CROSSING_TARGET: cfg_next.crossing_target = pwdata[COUNT_W-1:0];
                REG_TICKS_PER_UNIT:  cfg_next.ticks_per_unit  = pwdata[TICKS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_index)
            REG_PWM_PERIOD:      prdata = CFG_DW'(cfg_reg.pwm_period);
            REG_FULL_SPEED:      prdata = CFG_DW'(cfg_reg.full_speed);
            REG_TRIM_SPEED:      prdata = CFG_DW'(cfg_reg.trim_speed);
            REG_NORMAL_HOLD:     prdata = CFG_DW'(cfg_reg.normal_hold);
            REG_LONG_HOLD:       prdata = CFG_DW'(cfg_reg.long_hold);
            REG_CROSSING_TARGET: prdata = CFG_DW'(cfg_reg.crossing_target);
            REG_TICKS_PER_UNIT:  prdata = CFG_DW'(cfg_reg.ticks_per_unit);
            default:             prdata = '0;
        endcase
    end

    lfpc_step u_step (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .line_bits  (in_bits_reg),
        .state_next (state_step),
        .result     (result)
    );

    always_comb begin
        advance        = in_valid_reg && (!out_valid_reg || m_tready);
        s_tready       = !in_valid_reg || advance;
        in_valid_next  = s_tready ? s_tvalid : in_valid_reg;
        out_valid_next = advance || (out_valid_reg && !m_tready);
        state_next     = advance ? state_step : state_reg;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_DATA_W'(out_data_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pwm_period      <= RST_PWM_PERIOD;
            cfg_reg.full_speed      <= RST_FULL_SPEED;
            cfg_reg.trim_speed      <= RST_TRIM_SPEED;
            cfg_reg.normal_hold     <= RST_NORMAL_HOLD;
            cfg_reg.long_hold       <= RST_LONG_HOLD;
            cfg_reg.crossing_target <= RST_CROSSING_TARGET;
            cfg_reg.ticks_per_unit  <= RST_TICKS_PER_UNIT;
            state_reg.pwm_phase         <= '0;
            state_reg.hold_left         <= '0;
            state_reg.speed_a           <= '0;
            state_reg.speed_b           <= '0;
            state_reg.centre_prev_white <= 1'b1;
            state_reg.crossing_count    <= '0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            cfg_reg       <= cfg_next;
            state_reg     <= state_next;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_bits_reg <= s_tdata[LINE_W-1:0];
        end
        if (advance) begin
            out_data_reg <= result;
        end
    end

endmodule

`default_nettype wire
